// ----- rtl/core/gne_pkg.sv -----
package gne_pkg;

    localparam int IDX_W     = 20;
    localparam int DIR_W     = 3;
    localparam int NUM_DIRS  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd1;

    localparam logic [DIR_W-1:0] DIR_N  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_S  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_E  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_W_ = 3'd3;
    localparam logic [DIR_W-1:0] DIR_NE = 3'd4;
    localparam logic [DIR_W-1:0] DIR_NW = 3'd5;
    localparam logic [DIR_W-1:0] DIR_SE = 3'd6;
    localparam logic [DIR_W-1:0] DIR_SW = 3'd7;

    // One classified request waiting for enumeration.
    typedef struct packed {
        logic [IDX_W-1:0]    idx;
        logic [NUM_DIRS-1:0] mask;
        logic                invalid;
    } job_t;

    function automatic logic dir_up(logic [DIR_W-1:0] d);
        return (d == DIR_N) || (d == DIR_NE) || (d == DIR_NW);
    endfunction

    function automatic logic dir_down(logic [DIR_W-1:0] d);
        return (d == DIR_S) || (d == DIR_SE) || (d == DIR_SW);
    endfunction

    function automatic logic dir_right(logic [DIR_W-1:0] d);
        return (d == DIR_E) || (d == DIR_NE) || (d == DIR_SE);
    endfunction

    function automatic logic dir_left(logic [DIR_W-1:0] d);
        return (d == DIR_W_) || (d == DIR_NW) || (d == DIR_SW);
    endfunction

endpackage

// ----- rtl/core/grid_neighbour_enumerator_core.sv -----
// Moore neighbourhood enumerator for a row-major grid.
// cfg channel: cfg_index 0 writes the column count, 1 the row count; other
// indexes are dropped. Zero is taken as 1, values above MAX_SIDE saturate.
// cfg_ready is always high. Write config only while the block is drained.
// s channel: one request carries a linear cell index. The front splits it
// into row/column with a pipelined restoring divider (one quotient bit per
// stage, $clog2(MAX_SIDE+1) stages, capped at 11) and checks it against
// rows*cols. A two-entry queue feeds the back end, which emits one result
// per cycle unless m_ready stalls, in N,S,E,W,NE,NW,SE,SW order with last set on the final one.
// Out-of-range or neighbourless cells give one result with found=0.
// Path: divider stages, queue entry, back-end job register, output register.
// The front takes a request every cycle unless the full queue holds its last
// stage; the back end works on one request at a time and takes the next
// as it emits the last result of the current one.
// A stalled m_ready holds the output register; the queue then fills and
// s_ready drops once the divider's last stage is also occupied.
// Reset: sizes return to 1x1; valid, pointer and count state clears, data registers do not.
module grid_neighbour_enumerator_core #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gne_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gne_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [gne_pkg::IDX_W-1:0]         s_cell_index,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [gne_pkg::IDX_W-1:0]         m_neighbour_index,
    output logic [gne_pkg::DIR_W-1:0]         m_direction,
    output logic                              m_found,
    output logic                              m_last,
    output logic                              m_index_invalid
);

    localparam int SIDE_W = ($clog2(MAX_SIDE + 1) < gne_pkg::CFG_DATA_W)
                            ? $clog2(MAX_SIDE + 1) : gne_pkg::CFG_DATA_W;
    localparam int CW     = gne_pkg::IDX_W + SIDE_W;

    logic [SIDE_W-1:0]   cols_reg, cols_next;
    logic [SIDE_W-1:0]   rows_reg, rows_next;
    logic [2*SIDE_W-1:0] prod_reg, prod_next;
    logic [SIDE_W-1:0]   clamped;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (cfg_data == '0) begin
            clamped = SIDE_W'(1);
        end else if (32'(cfg_data) > MAX_SIDE) begin
            clamped = SIDE_W'(MAX_SIDE);
        end else begin
            clamped = SIDE_W'(cfg_data);
        end
    end

    always_comb begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                gne_pkg::CFG_GRID_COLS: cols_next = clamped;
                gne_pkg::CFG_GRID_ROWS: rows_next = clamped;
                default: ;
            endcase
        end
        prod_next = {{SIDE_W{1'b0}}, rows_reg} * {{SIDE_W{1'b0}}, cols_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= SIDE_W'(1);
            rows_reg <= SIDE_W'(1);
            prod_reg <= (2*SIDE_W)'(1);
        end else begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
            prod_reg <= prod_next;
        end
    end

    logic          front_valid, q_in_ready;
    gne_pkg::job_t front_job;
    logic          q_out_valid, back_ready;
    gne_pkg::job_t q_job;

    gne_front #(.SIDE_W(SIDE_W)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_cell_index (s_cell_index),
        .cols          (cols_reg),
        .rows          (rows_reg),
        .prod          (prod_reg),
        .out_valid     (front_valid),
        .out_ready     (q_in_ready),
        .out_job       (front_job)
    );

    gne_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (q_in_ready),
        .in_job    (front_job),
        .out_valid (q_out_valid),
        .out_ready (back_ready),
        .out_job   (q_job)
    );

    gne_back #(.SIDE_W(SIDE_W)) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cols              (cols_reg),
        .in_valid          (q_out_valid),
        .in_ready          (back_ready),
        .in_job            (q_job),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_neighbour_index (m_neighbour_index),
        .m_direction       (m_direction),
        .m_found           (m_found),
        .m_last            (m_last),
        .m_index_invalid   (m_index_invalid)
    );

    a_invalid_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_index_invalid |->
            !m_found && m_last && (m_direction == gne_pkg::DIR_N)
            && (m_neighbour_index == '0))
        else $error("out-of-range request produced a non-terminal result");

    a_found_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |->
            ({{SIDE_W{1'b0}}, m_neighbour_index} < {{(CW-2*SIDE_W){1'b0}}, prod_reg}))
        else $error("neighbour index lies outside the grid");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> front_valid && !q_in_ready)
        else $error("input stalled without a full queue");

    a_queue_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        q_out_valid && back_ready |=> $past(q_in_ready) || q_in_ready)
        else $error("queue stayed full after a pop");

endmodule

// ----- rtl/core/gne_front.sv -----
module gne_front #(
    parameter int SIDE_W = 11
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [gne_pkg::IDX_W-1:0]   in_cell_index,
    input  logic [SIDE_W-1:0]           cols,
    input  logic [SIDE_W-1:0]           rows,
    input  logic [2*SIDE_W-1:0]         prod,
    output logic                        out_valid,
    input  logic                        out_ready,
    output gne_pkg::job_t               out_job
);

    localparam int QW = SIDE_W;
    localparam int CW = gne_pkg::IDX_W + SIDE_W;

    logic                      vld_reg [QW];
    logic [gne_pkg::IDX_W-1:0] idx_reg [QW];
    logic [CW-1:0]             rem_reg [QW];
    logic [QW-1:0]             q_reg   [QW];

    logic                      vld_in  [QW];
    logic [gne_pkg::IDX_W-1:0] idx_in  [QW];
    logic [CW-1:0]             rem_in  [QW];
    logic [QW-1:0]             q_in    [QW];
    logic [CW-1:0]             rem_next [QW];
    logic [QW-1:0]             q_next   [QW];

    logic adv;

    // whole pipeline moves together; it only halts when the last stage can't drain
    assign adv       = !vld_reg[QW-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[QW-1];

    // restoring divider, one quotient bit per stage, MSB first
    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int K = QW - 1 - s;
        logic [CW-1:0] trial;
        logic          ge;

        if (s == 0) begin : g_first
            assign vld_in[s] = in_valid;
            assign idx_in[s] = in_cell_index;
            assign rem_in[s] = {{SIDE_W{1'b0}}, in_cell_index};
            assign q_in[s]   = '0;
        end else begin : g_rest
            assign vld_in[s] = vld_reg[s-1];
            assign idx_in[s] = idx_reg[s-1];
            assign rem_in[s] = rem_reg[s-1];
            assign q_in[s]   = q_reg[s-1];
        end

        assign trial       = {{gne_pkg::IDX_W{1'b0}}, cols} << K;
        assign ge          = rem_in[s] >= trial;
        assign rem_next[s] = ge ? (rem_in[s] - trial) : rem_in[s];
        assign q_next[s]   = q_in[s] | (QW'(ge) << K);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (adv) begin
                vld_reg[s] <= vld_in[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                idx_reg[s] <= idx_in[s];
                rem_reg[s] <= rem_next[s];
                q_reg[s]   <= q_next[s];
            end
        end
    end

    // classify: range check and which of the eight neighbours exist
    logic [QW-1:0]     row;
    logic [SIDE_W-1:0] col;
    logic              has_up, has_down, has_left, has_right;

    assign row       = q_reg[QW-1];
    assign col       = rem_reg[QW-1][SIDE_W-1:0];
    assign has_up    = row != '0;
    assign has_down  = ({1'b0, row} + 1'b1) < {1'b0, rows};
    assign has_left  = col != '0;
    assign has_right = ({1'b0, col} + 1'b1) < {1'b0, cols};

    always_comb begin
        logic [gne_pkg::DIR_W-1:0] d;
        out_job.idx     = idx_reg[QW-1];
        out_job.invalid = {{SIDE_W{1'b0}}, idx_reg[QW-1]}
                          >= {{(CW-2*SIDE_W){1'b0}}, prod};
        for (int i = 0; i < gne_pkg::NUM_DIRS; i++) begin
            d = gne_pkg::DIR_W'(i);
            out_job.mask[i] = (!gne_pkg::dir_up(d)    || has_up)
                           && (!gne_pkg::dir_down(d)  || has_down)
                           && (!gne_pkg::dir_left(d)  || has_left)
                           && (!gne_pkg::dir_right(d) || has_right);
        end
    end

endmodule

// ----- rtl/core/gne_queue.sv -----
module gne_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  gne_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_ready,
    output gne_pkg::job_t out_job
);

    gne_pkg::job_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_job   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

// ----- rtl/core/gne_back.sv -----
module gne_back #(
    parameter int SIDE_W = 11
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [SIDE_W-1:0]             cols,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  gne_pkg::job_t                 in_job,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gne_pkg::IDX_W-1:0]     m_neighbour_index,
    output logic [gne_pkg::DIR_W-1:0]     m_direction,
    output logic                          m_found,
    output logic                          m_last,
    output logic                          m_index_invalid
);

    localparam int IW = gne_pkg::IDX_W;

    logic                         act_reg, act_next;
    logic [IW-1:0]                idx_reg, idx_next;
    logic [gne_pkg::NUM_DIRS-1:0] mask_reg, mask_next;
    logic                         inv_reg, inv_next;

    logic                         ov_reg, ov_next;
    logic [IW-1:0]                onb_reg, onb_next;
    logic [gne_pkg::DIR_W-1:0]    odir_reg, odir_next;
    logic                         ofound_reg, ofound_next;
    logic                         olast_reg, olast_next;
    logic                         oinv_reg, oinv_next;

    logic                         emit, special, done;
    logic [gne_pkg::DIR_W-1:0]    sel;
    logic [gne_pkg::NUM_DIRS-1:0] rest;
    logic [IW-1:0]                cols_x, nb;

    assign emit    = act_reg && (!ov_reg || m_ready);
    assign special = inv_reg || (mask_reg == '0);
    assign done    = emit && (special || (rest == '0));
    assign in_ready = !act_reg || done;
    assign cols_x  = {{(IW-SIDE_W){1'b0}}, cols};

    // lowest pending direction goes first
    always_comb begin
        sel = '0;
        for (int i = gne_pkg::NUM_DIRS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel = gne_pkg::DIR_W'(i);
            end
        end
        rest = mask_reg & ~(gne_pkg::NUM_DIRS'(1) << sel);
    end

    always_comb begin
        nb = idx_reg;
        if (gne_pkg::dir_up(sel))    nb = nb - cols_x;
        if (gne_pkg::dir_down(sel))  nb = nb + cols_x;
        if (gne_pkg::dir_right(sel)) nb = nb + IW'(1);
        if (gne_pkg::dir_left(sel))  nb = nb - IW'(1);
    end

    always_comb begin
        act_next  = act_reg;
        idx_next  = idx_reg;
        mask_next = mask_reg;
        inv_next  = inv_reg;
        if (in_valid && in_ready) begin
            act_next  = 1'b1;
            idx_next  = in_job.idx;
            mask_next = in_job.mask;
            inv_next  = in_job.invalid;
        end else if (done) begin
            act_next = 1'b0;
        end else if (emit) begin
            mask_next = rest;
        end
    end

    always_comb begin
        ov_next     = ov_reg && !m_ready;
        onb_next    = onb_reg;
        odir_next   = odir_reg;
        ofound_next = ofound_reg;
        olast_next  = olast_reg;
        oinv_next   = oinv_reg;
        if (emit) begin
            ov_next = 1'b1;
            if (special) begin
                onb_next    = '0;
                odir_next   = gne_pkg::DIR_N;
                ofound_next = 1'b0;
                olast_next  = 1'b1;
                oinv_next   = inv_reg;
            end else begin
                onb_next    = nb;
                odir_next   = sel;
                ofound_next = 1'b1;
                olast_next  = rest == '0;
                oinv_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end else begin
            act_reg <= act_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        mask_reg   <= mask_next;
        inv_reg    <= inv_next;
        onb_reg    <= onb_next;
        odir_reg   <= odir_next;
        ofound_reg <= ofound_next;
        olast_reg  <= olast_next;
        oinv_reg   <= oinv_next;
    end

    assign m_valid           = ov_reg;
    assign m_neighbour_index = onb_reg;
    assign m_direction       = odir_reg;
    assign m_found           = ofound_reg;
    assign m_last            = olast_reg;
    assign m_index_invalid   = oinv_reg;

endmodule
